>>> rtl/pbp_pkg.sv
// Package for packet block placement: widths, disposition codes, sequencer states.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none
package pbp_pkg;

   localparam int MAX_ADVANCES = 63;
   localparam int OFFSET_BITS  = 48;
   localparam int ADV_W        = $clog2(MAX_ADVANCES + 1);

   localparam int OFS_W  = 48;
   localparam int PAY_W  = 16;
   localparam int BS_W   = 33;
   localparam int FILL_W = 33;
   localparam int WOFF_W = 32;
   localparam int DISP_W = 3;

   localparam int WIN_W  = OFFSET_BITS;
   localparam int SPAN_W = (OFFSET_BITS > OFS_W) ? OFFSET_BITS : OFS_W;
   localparam int ALU_W  = SPAN_W + 2;

   localparam logic [BS_W-1:0] BS_RESET = BS_W'(128 * 1024 * 1024);

   typedef enum logic [DISP_W-1:0] {
      DISP_INVALID  = 3'd0,
      DISP_CURRENT  = 3'd1,
      DISP_OVERFLOW = 3'd2,
      DISP_LATE     = 3'd3,
      DISP_CLOSED   = 3'd4,
      DISP_FAR      = 3'd5
   } disp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CUR,
      ST_OVF,
      ST_ADDC,
      ST_ADDO,
      ST_FULL,
      ST_RES,
      ST_MISS,
      ST_ADV
   } state_type;

endpackage
`default_nettype wire

>>> rtl/pbp_if.sv
// Word channels of packet block placement: packet request, placement response, block size write.
// Depends on pbp_pkg for field widths.
`default_nettype none
interface pbp_req_if import pbp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OFS_W-1:0] packet_offset;
   logic [PAY_W-1:0]        payload_bytes;
   modport source (output valid, output packet_offset, output payload_bytes, input ready);
   modport sink   (input valid, input packet_offset, input payload_bytes, output ready);
endinterface

interface pbp_rsp_if import pbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DISP_W-1:0] disposition;
   logic              buffer_select;
   logic [WOFF_W-1:0] write_offset;
   logic [BS_W-1:0]   missing_bytes;
   logic              last_result;
   modport source (output valid, output disposition, output buffer_select,
                   output write_offset, output missing_bytes, output last_result,
                   input ready);
   modport sink   (input valid, input disposition, input buffer_select,
                   input write_offset, input missing_bytes, input last_result,
                   output ready);
endinterface

interface pbp_csr_if import pbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [BS_W-1:0] block_size;
   modport source (output valid, output block_size, input ready);
   modport sink   (input valid, input block_size, output ready);
endinterface
`default_nettype wire

>>> rtl/packet_block_placement_core.sv
// A packet is accepted only in ST_IDLE and walks the sequencer from ST_DIFF to ST_RES for
// its response word; each window advance, and the close of a block that a stored packet
// fills, runs ST_MISS and ST_ADV for its close word. No new packet is taken until the last
// is done. Every step uses the single shared add/subtract unit at most once.
// Reset: synchronous, clears window, fills and swap, block_size back to 128 MiB; no sweep.
// Depends on pbp_pkg and pbp_if.
`default_nettype none
module packet_block_placement_core import pbp_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   pbp_req_if.sink      req_ch,
   pbp_rsp_if.source    rsp_ch,
   pbp_csr_if.sink      csr_ch
);

   state_type          state_ff, state_in;
   logic [OFS_W-1:0]   raw_ff, raw_in;
   logic [PAY_W-1:0]   pay_ff, pay_in;
   logic [WIN_W-1:0]   ws_ff, ws_in;
   logic [FILL_W-1:0]  cur_fill_ff, cur_fill_in;
   logic [FILL_W-1:0]  ovf_fill_ff, ovf_fill_in;
   logic               needed_ff, needed_in;
   logic               swap_ff, swap_in;
   logic [BS_W-1:0]    bs_ff, bs_in;
   logic [SPAN_W-1:0]  d_ff, d_in;
   logic [ADV_W-1:0]   closes_ff, closes_in;
   logic               close_pend_ff, close_pend_in;
   logic               final_close_ff, final_close_in;
   disp_type           disp_ff, disp_in;
   logic               sel_ff, sel_in;
   logic [WOFF_W-1:0]  woff_ff, woff_in;
   logic [BS_W-1:0]    miss_ff, miss_in;

   logic               out_valid_ff, out_valid_in;
   disp_type           out_disp_ff, out_disp_in;
   logic               out_sel_ff, out_sel_in;
   logic [WOFF_W-1:0]  out_woff_ff, out_woff_in;
   logic [BS_W-1:0]    out_drop_ff, out_drop_in;
   logic               out_last_ff, out_last_in;

   logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
   logic               alu_sub, alu_neg;
   logic               out_free, accept;
   logic [FILL_W-1:0]  sat_sum;

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign accept                = req_ch.valid && req_ch.ready;
   assign out_free              = !out_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.disposition    = out_disp_ff;
   assign rsp_ch.buffer_select  = out_sel_ff;
   assign rsp_ch.write_offset   = out_woff_ff;
   assign rsp_ch.missing_bytes  = out_drop_ff;
   assign rsp_ch.last_result    = out_last_ff;

   // shared add/subtract unit
   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg = alu_res[ALU_W-1];
   assign sat_sum = alu_res[FILL_W] ? {FILL_W{1'b1}} : alu_res[FILL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ws_ff         <= '0;
         cur_fill_ff   <= '0;
         ovf_fill_ff   <= '0;
         needed_ff     <= 1'b1;
         swap_ff       <= 1'b0;
         bs_ff         <= BS_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ws_ff         <= ws_in;
         cur_fill_ff   <= cur_fill_in;
         ovf_fill_ff   <= ovf_fill_in;
         needed_ff     <= needed_in;
         swap_ff       <= swap_in;
         bs_ff         <= bs_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff         <= raw_in;
      pay_ff         <= pay_in;
      d_ff           <= d_in;
      closes_ff      <= closes_in;
      close_pend_ff  <= close_pend_in;
      final_close_ff <= final_close_in;
      disp_ff        <= disp_in;
      sel_ff         <= sel_in;
      woff_ff        <= woff_in;
      miss_ff        <= miss_in;
      out_disp_ff    <= out_disp_in;
      out_sel_ff     <= out_sel_in;
      out_woff_ff    <= out_woff_in;
      out_drop_ff    <= out_drop_in;
      out_last_ff    <= out_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      raw_in         = raw_ff;
      pay_in         = pay_ff;
      ws_in          = ws_ff;
      cur_fill_in    = cur_fill_ff;
      ovf_fill_in    = ovf_fill_ff;
      needed_in      = needed_ff;
      swap_in        = swap_ff;
      bs_in          = (csr_ch.valid && csr_ch.ready) ? csr_ch.block_size : bs_ff;
      d_in           = d_ff;
      closes_in      = closes_ff;
      close_pend_in  = close_pend_ff;
      final_close_in = final_close_ff;
      disp_in        = disp_ff;
      sel_in         = sel_ff;
      woff_in        = woff_ff;
      miss_in        = miss_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_disp_in    = out_disp_ff;
      out_sel_in     = out_sel_ff;
      out_woff_in    = out_woff_ff;
      out_drop_in    = out_drop_ff;
      out_last_in    = out_last_ff;
      alu_a          = '0;
      alu_b          = '0;
      alu_sub        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               raw_in    = req_ch.packet_offset;
               pay_in    = req_ch.payload_bytes;
               closes_in = '0;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            alu_a = ALU_W'(raw_ff);
            alu_b = ALU_W'(ws_ff);
            if (needed_ff) begin
               swap_in     = !swap_ff;
               cur_fill_in = ovf_fill_ff;
               ovf_fill_in = '0;
               needed_in   = 1'b0;
            end
            sel_in  = needed_ff ? !swap_ff : swap_ff;
            woff_in = '0;
            d_in    = alu_res[SPAN_W-1:0];
            if (raw_ff[OFS_W-1]) begin
               disp_in  = DISP_INVALID;
               state_in = ST_FULL;
            end else if (alu_neg) begin
               disp_in  = DISP_LATE;
               state_in = ST_FULL;
            end else begin
               state_in = ST_CUR;
            end
         end
         ST_CUR: begin
            alu_a = ALU_W'(d_ff);
            alu_b = ALU_W'(bs_ff);
            if (alu_neg) begin
               disp_in  = DISP_CURRENT;
               sel_in   = swap_ff;
               woff_in  = d_ff[WOFF_W-1:0];
               state_in = ST_ADDC;
            end else begin
               d_in     = alu_res[SPAN_W-1:0];
               state_in = ST_OVF;
            end
         end
         ST_OVF: begin
            alu_a = ALU_W'(d_ff);
            alu_b = ALU_W'(bs_ff);
            if (alu_neg) begin
               disp_in  = DISP_OVERFLOW;
               sel_in   = !swap_ff;
               woff_in  = d_ff[WOFF_W-1:0];
               state_in = ST_ADDO;
            end else if (closes_ff == ADV_W'(MAX_ADVANCES)) begin
               disp_in       = DISP_FAR;
               sel_in        = swap_ff;
               woff_in       = '0;
               close_pend_in = 1'b0;
               state_in      = ST_RES;
            end else begin
               final_close_in = 1'b0;
               state_in       = ST_MISS;
            end
         end
         ST_ADDC: begin
            alu_sub     = 1'b0;
            alu_a       = ALU_W'(cur_fill_ff);
            alu_b       = ALU_W'(pay_ff);
            cur_fill_in = sat_sum;
            state_in    = ST_FULL;
         end
         ST_ADDO: begin
            alu_sub     = 1'b0;
            alu_a       = ALU_W'(ovf_fill_ff);
            alu_b       = ALU_W'(pay_ff);
            ovf_fill_in = sat_sum;
            state_in    = ST_FULL;
         end
         ST_FULL: begin
            alu_a          = ALU_W'(cur_fill_ff);
            alu_b          = ALU_W'(bs_ff);
            close_pend_in  = !alu_neg && (closes_ff < ADV_W'(MAX_ADVANCES));
            final_close_in = 1'b1;
            state_in       = ST_RES;
         end
         ST_RES: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_disp_in  = disp_ff;
               out_sel_in   = sel_ff;
               out_woff_in  = woff_ff;
               out_drop_in  = '0;
               out_last_in  = !close_pend_ff;
               state_in     = close_pend_ff ? ST_MISS : ST_IDLE;
            end
         end
         ST_MISS: begin
            alu_a    = ALU_W'(bs_ff);
            alu_b    = ALU_W'(cur_fill_ff);
            miss_in  = alu_neg ? '0 : alu_res[BS_W-1:0];
            state_in = ST_ADV;
         end
         ST_ADV: begin
            alu_sub = 1'b0;
            alu_a   = ALU_W'(ws_ff);
            alu_b   = ALU_W'(bs_ff);
            if (out_free) begin
               out_valid_in = 1'b1;
               out_disp_in  = DISP_CLOSED;
               out_sel_in   = swap_ff;
               out_woff_in  = '0;
               out_drop_in  = miss_ff;
               out_last_in  = final_close_ff;
               ws_in        = alu_res[WIN_W-1:0];
               needed_in    = 1'b1;
               if (final_close_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  closes_in = closes_ff + 1'b1;
                  state_in  = ST_DIFF;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_closes_cap: assert property (@(posedge clock) disable iff (reset)
      closes_ff <= ADV_W'(MAX_ADVANCES) || state_ff == ST_IDLE)
      else $error("advance count above cap");

   a_far_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.disposition == DISP_FAR |-> rsp_ch.last_result)
      else $error("too-far word not final");

   a_drop_only_close: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.disposition != DISP_CLOSED |-> rsp_ch.missing_bytes == '0)
      else $error("missing bytes on non-close word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("ready right after accept");
`endif

endmodule
`default_nettype wire

>>> bench/packet_block_placement_core_test.sv
// Self-checking bench for packet_block_placement_core: drives packets and block size
// writes, predicts every placement word and checks the response channel in order.
// Depends on pbp_pkg, pbp_if and the core.
module packet_block_placement_core_test;
   import pbp_pkg::*;

   localparam int          QUIET_LIMIT = 3000;
   localparam logic [63:0] OFS_MAX     = (64'd1 << 47) - 64'd1;

   typedef struct {
      logic [OFS_W-1:0] offset;
      logic [PAY_W-1:0] payload;
   } packet_type;

   typedef struct {
      disp_type          disposition;
      logic              buffer_select;
      logic [WOFF_W-1:0] write_offset;
      logic [BS_W-1:0]   missing_bytes;
      logic              last_result;
   } placement_type;

   logic clock;
   logic reset;

   pbp_req_if req_ch ();
   pbp_rsp_if rsp_ch ();
   pbp_csr_if csr_ch ();

   packet_block_placement_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   packet_type    packets_waiting[$];
   placement_type placements_due[$];

   // window state as the block should hold it
   logic [BS_W-1:0]   block_size_now = BS_RESET;
   logic [WIN_W-1:0]  window_start   = '0;
   logic [FILL_W-1:0] current_fill   = '0;
   logic [FILL_W-1:0] overflow_fill  = '0;
   logic              block_pending  = 1'b1;
   logic              buffer_swap    = 1'b0;

   int unsigned packets_accepted = 0;
   int unsigned words_checked    = 0;
   int unsigned blocks_closed    = 0;
   int unsigned far_drops        = 0;
   int unsigned sizes_tried      = 1;
   int unsigned mismatches       = 0;
   int unsigned quiet_cycles     = 0;
   int unsigned hold_left        = 0;
   bit          hold_done        = 0;
   bit          steady_run       = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic void note_placement(input disp_type disp, input logic sel,
                                          input logic [63:0] woff,
                                          input logic [BS_W-1:0] dropped, input logic last);
      placement_type w;
      w.disposition   = disp;
      w.buffer_select = sel;
      w.write_offset  = woff[WOFF_W-1:0];
      w.missing_bytes = dropped;
      w.last_result   = last;
      placements_due.push_back(w);
   endfunction

   function automatic logic [FILL_W-1:0] fill_add(input logic [FILL_W-1:0] fill,
                                                  input logic [PAY_W-1:0] pay);
      logic [FILL_W:0] sum;
      sum = fill + pay;
      return sum[FILL_W] ? '1 : sum[FILL_W-1:0];
   endfunction

   function automatic void start_window_block();
      buffer_swap   = ~buffer_swap;
      current_fill  = overflow_fill;
      overflow_fill = '0;
      block_pending = 1'b0;
   endfunction

   function automatic logic [BS_W-1:0] retire_window_block();
      logic [BS_W-1:0] missing;
      missing       = (block_size_now > current_fill) ? block_size_now - current_fill : '0;
      block_pending = 1'b1;
      window_start  = window_start + WIN_W'(block_size_now);
      blocks_closed++;
      return missing;
   endfunction

   function automatic void place_packet(input logic [OFS_W-1:0] ofs,
                                        input logic [PAY_W-1:0] pay);
      logic [63:0] raw;
      logic [63:0] bs;
      logic [63:0] d;
      logic [63:0] woff;
      int unsigned advances;
      disp_type    disp;
      logic        sel;
      raw      = 64'(ofs);
      bs       = 64'(block_size_now);
      advances = 0;
      forever begin
         if (block_pending) start_window_block();
         sel  = buffer_swap;
         woff = '0;
         if (ofs[OFS_W-1]) begin
            disp = DISP_INVALID;
         end else if (raw < 64'(window_start)) begin
            disp = DISP_LATE;
         end else begin
            d = raw - 64'(window_start);
            if (d < bs) begin
               disp         = DISP_CURRENT;
               woff         = d;
               current_fill = fill_add(current_fill, pay);
            end else if (d - bs < bs) begin
               disp          = DISP_OVERFLOW;
               woff          = d - bs;
               sel           = ~buffer_swap;
               overflow_fill = fill_add(overflow_fill, pay);
            end else if (advances >= MAX_ADVANCES) begin
               note_placement(DISP_FAR, buffer_swap, '0, '0, 1'b1);
               far_drops++;
               return;
            end else begin
               note_placement(DISP_CLOSED, buffer_swap, '0, retire_window_block(), 1'b0);
               advances++;
               continue;
            end
         end
         if (64'(current_fill) >= bs && advances < MAX_ADVANCES) begin
            note_placement(disp, sel, woff, '0, 1'b0);
            note_placement(DISP_CLOSED, buffer_swap, '0, retire_window_block(), 1'b1);
         end else begin
            note_placement(disp, sel, woff, '0, 1'b1);
         end
         return;
      end
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] below(input logic [63:0] n);
      return (n == 0) ? 64'd0 : rand64() % n;
   endfunction

   // mostly in-window words, some late, far, negative and raw noise
   function automatic packet_type random_packet();
      packet_type  p;
      logic [63:0] bs;
      logic [63:0] base;
      logic [63:0] ofs;
      int unsigned pick;
      int unsigned pay_pick;
      bs   = 64'(block_size_now);
      base = 64'(window_start);
      pick = $urandom_range(99);
      if (pick < 35)                    ofs = base + below(bs);
      else if (pick < 60)               ofs = base + bs + below(bs);
      else if (pick < 68 && base != 0)  ofs = below(base);
      else if (pick < 82)               ofs = base + bs * $urandom_range(2, 5) + below(bs);
      else if (pick < 86)               ofs = below(OFS_MAX + 1);
      else                              ofs = base;
      if (ofs > OFS_MAX) ofs = OFS_MAX;
      if (pick >= 92) begin
         ofs     = rand64();
         ofs[47] = 1'b1;
         if (pick == 99) ofs = -64'sd2;
      end else if (pick >= 88) begin
         ofs = rand64();
      end
      pay_pick = $urandom_range(99);
      p.offset = ofs[OFS_W-1:0];
      if (pay_pick < 70)      p.payload = PAY_W'($urandom_range(65535));
      else if (pay_pick < 85) p.payload = PAY_W'($urandom_range(16));
      else if (pay_pick < 93) p.payload = '1;
      else                    p.payload = '0;
      return p;
   endfunction

   always @(posedge clock) begin : drive_packets
      packet_type p;
      logic       offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            place_packet(req_ch.packet_offset, req_ch.payload_bytes);
            packets_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            offer = packets_waiting.size() != 0 && (steady_run || $urandom_range(99) >= 14);
            if (offer) begin
               p = packets_waiting.pop_front();
               req_ch.packet_offset <= p.offset;
               req_ch.payload_bytes <= p.payload;
            end
            req_ch.valid <= offer;
         end
      end
   end

   always @(posedge clock) begin : check_placements
      placement_type w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_checked++;
            if (placements_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: disp %0d sel %0b woff %h drop %h last %b",
                           rsp_ch.disposition, rsp_ch.buffer_select, rsp_ch.write_offset,
                           rsp_ch.missing_bytes, rsp_ch.last_result);
            end else begin
               w = placements_due.pop_front();
               if (rsp_ch.disposition !== w.disposition ||
                   rsp_ch.buffer_select !== w.buffer_select ||
                   rsp_ch.write_offset !== w.write_offset ||
                   rsp_ch.missing_bytes !== w.missing_bytes ||
                   rsp_ch.last_result !== w.last_result) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("word %0d exp: disp %0d sel %0b woff %h drop %h last %b",
                              words_checked, w.disposition, w.buffer_select,
                              w.write_offset, w.missing_bytes, w.last_result);
                     $display("word %0d got: disp %0d sel %0b woff %h drop %h last %b",
                              words_checked, rsp_ch.disposition, rsp_ch.buffer_select,
                              rsp_ch.write_offset, rsp_ch.missing_bytes,
                              rsp_ch.last_result);
                  end
               end
            end
         end
         // one long back-pressure window so the core backs up into its input
         if (hold_left != 0) begin
            hold_left--;
         end else if (!hold_done && packets_accepted >= 60) begin
            hold_left = 300;
            hold_done = 1;
         end
         rsp_ch.ready <= hold_left == 0 && (steady_run || $urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d words outstanding",
                     QUIET_LIMIT, placements_due.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic settle();
      while (packets_waiting.size() != 0 || req_ch.valid || placements_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_block_size(input logic [BS_W-1:0] value);
      settle();
      @(posedge clock);
      csr_ch.block_size <= value;
      csr_ch.valid      <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      block_size_now = value;
      csr_ch.valid  <= 1'b0;
      sizes_tried++;
   endtask

   task automatic place_now(input logic [63:0] ofs, input logic [PAY_W-1:0] pay);
      packet_type p;
      p.offset  = ofs[OFS_W-1:0];
      p.payload = pay;
      packets_waiting.push_back(p);
      settle();
   endtask

   task automatic random_packets(input int unsigned count);
      repeat (count) begin
         while (packets_waiting.size() >= 4) @(posedge clock);
         packets_waiting.push_back(random_packet());
      end
   endtask

   initial begin : stimulus
      reset                 <= 1'b1;
      csr_ch.valid          <= 1'b0;
      csr_ch.block_size     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset block size: negatives, overflow, two advances, late, capped far
      place_now(64'd0, 16'd0);
      place_now(-64'sd2, 16'd0);
      place_now(64'h0000_8000_0000_0000, 16'hFFFF);
      place_now(-64'sd1, 16'd1);
      place_now(64'(window_start) + 64'(block_size_now) + 64'd5, 16'hFFFF);
      place_now(64'(window_start) + 3 * 64'(block_size_now), 16'd100);
      place_now(64'd0, 16'd7);
      place_now(OFS_MAX, 16'hFFFF);

      // one-byte blocks: fill closes on every stored byte
      write_block_size(BS_W'(1));
      place_now(64'(window_start), 16'd0);
      place_now(64'(window_start), 16'd1);
      place_now(64'(window_start) + 64'd1, 16'd5);
      place_now(64'(window_start) + 64'd5, 16'd9);
      place_now(64'd0, 16'd3);
      place_now(-64'sd1, 16'hFFFF);
      random_packets(30);

      // zero block size: window stuck, everything ahead runs out of advances
      write_block_size('0);
      place_now(-64'sd2, 16'd0);
      place_now(64'(window_start) - 64'd1, 16'd1);
      place_now(64'(window_start), 16'd4);

      write_block_size(BS_W'(64'h1_0000_0000));
      place_now(64'(window_start) + 64'hFFFF_FFFF, 16'hFFFF);
      place_now(64'(window_start) + 64'h1_FFFF_FFFF, 16'd1);
      place_now(64'(window_start) + 64'h3_0000_0000, 16'd2);
      random_packets(25);

      write_block_size(BS_W'(300));
      steady_run = 1;
      random_packets(50);
      settle();
      steady_run = 0;

      write_block_size(BS_W'(65536));
      random_packets(50);

      write_block_size(BS_W'($urandom_range(1, 1 << 20)));
      random_packets(50);

      write_block_size(BS_RESET);
      random_packets(40);

      settle();
      repeat (40) @(posedge clock);
      if (placements_due.size() != 0) mismatches++;
      $display("%0d packets over %0d block sizes gave %0d words: %0d closes, %0d too far.",
               packets_accepted, sizes_tried, words_checked, blocks_closed, far_drops);
      $display("%0d mismatching words.", mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
